>>> hw/rtl/sawbc_pkg.sv
// Shared types and codes for the set-associative write-back cache tag engine.
// Request and response payloads, command and counter codes, event group.
// No dependencies.
package sawbc_pkg;

    localparam int ADDR_W = 64;
    localparam int CNT_W  = 64;
    localparam int CMD_W  = 3;
    localparam int SEL_W  = 2;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_READ       = 3'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE      = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PROBE      = 3'd2;
    localparam logic [CMD_W-1:0] CMD_INVALIDATE = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FLUSH      = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_CNT   = 3'd5;
    localparam logic [CMD_W-1:0] CMD_CLEAR_CNT  = 3'd6;

    // Counter select codes
    localparam logic [SEL_W-1:0] SEL_HITS       = 2'd0;
    localparam logic [SEL_W-1:0] SEL_MISSES     = 2'd1;
    localparam logic [SEL_W-1:0] SEL_EVICTIONS  = 2'd2;
    localparam logic [SEL_W-1:0] SEL_WRITEBACKS = 2'd3;

    typedef struct packed {
        logic [CMD_W-1:0]  cmd;
        logic [ADDR_W-1:0] address;
        logic [SEL_W-1:0]  counter_select;
    } req_t;

    typedef struct packed {
        logic              hit;
        logic              writeback_valid;
        logic [ADDR_W-1:0] writeback_address;
        logic [CNT_W-1:0]  counter_value;
    } rsp_t;

    // Counter events raised by one request
    typedef struct packed {
        logic hit;
        logic miss;
        logic evict;
        logic wback;
    } cnt_evt_t;

endpackage

>>> hw/rtl/set_assoc_writeback_cache_tags_core.sv
// Tag and state engine of a set-associative write-back cache (uses sawbc_pkg,
// sawbc_tag_ram, sawbc_lookup). A request is registered into stage 1 with its set row read,
// then into the response register; one request per cycle while the response side does not stall.
// Reset: counters zero, LRU mode; then a clearing pass writes every set row
// (all invalid, ranks equal way index) with requests stalled.
module set_assoc_writeback_cache_tags_core #(
    parameter int LINE_BYTES = 64,
    parameter int SETS = 128,
    parameter int WAYS = 4
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  sawbc_pkg::req_t   req,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output sawbc_pkg::rsp_t   rsp,
    input  logic              cfg_write,
    input  logic              cfg_data
);
    import sawbc_pkg::*;

    localparam int OFF_W  = $clog2(LINE_BYTES);
    localparam int SET_W  = $clog2(SETS);
    localparam int SET_IW = (SETS > 1) ? SET_W : 1;
    localparam int TAG_W  = ADDR_W - OFF_W - SET_W;
    localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int ROW_W  = WAYS * (2 + TAG_W + RANK_W);

    typedef struct packed {
        logic [WAYS-1:0]              valid;
        logic [WAYS-1:0]              dirty;
        logic [WAYS-1:0][TAG_W-1:0]   tag;
        logic [WAYS-1:0][RANK_W-1:0]  rank;
    } row_t;

    logic              mode_reg;
    logic              clr_active_reg;
    logic [SET_IW-1:0] clr_idx_reg;
    logic              s1_valid_reg;
    logic [CMD_W-1:0]  s1_cmd_reg;
    logic [TAG_W-1:0]  s1_tag_reg;
    logic [SET_IW-1:0] s1_set_reg;
    logic [SEL_W-1:0]  s1_sel_reg;
    logic              byp_reg;
    logic              byp_next;
    logic [ROW_W-1:0]  byp_row_reg;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;
    rsp_t              rsp_next;
    logic [CNT_W-1:0]  hit_cnt_reg;
    logic [CNT_W-1:0]  miss_cnt_reg;
    logic [CNT_W-1:0]  evict_cnt_reg;
    logic [CNT_W-1:0]  wb_cnt_reg;
    logic [CNT_W-1:0]  cnt_sel;

    logic              accept;
    logic              s1_adv;
    logic              s1_fire;
    logic [SET_IW-1:0] in_set;
    logic [TAG_W-1:0]  in_tag;
    row_t              rst_row;
    logic              ram_wr_en;
    logic [SET_IW-1:0] ram_wr_addr;
    logic [ROW_W-1:0]  ram_wr_data;
    logic [ROW_W-1:0]  ram_rd_data;
    logic [ROW_W-1:0]  s1_row;
    logic [ROW_W-1:0]  lk_row;
    logic              lk_we;
    logic              row_we;
    logic              lk_hit;
    logic              lk_wb_valid;
    logic [TAG_W-1:0]  lk_wb_tag;
    cnt_evt_t          evt;

    // Split the request address
    assign in_set = SET_IW'((req.address >> OFF_W) & ADDR_W'(SETS - 1));
    assign in_tag = TAG_W'(req.address >> (OFF_W + SET_W));

    // Handshake
    assign s1_adv    = !rsp_valid_reg || !rsp_stall;
    assign s1_fire   = s1_valid_reg && s1_adv;
    assign req_stall = clr_active_reg || (s1_valid_reg && !s1_adv);
    assign accept    = req_valid && !req_stall;
    assign row_we    = s1_fire && lk_we;

    // Configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_write)
        begin
            mode_reg <= cfg_data;
        end
    end

    // Clearing pass over all set rows after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == SET_IW'(SETS - 1))
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    always_comb
    begin
        rst_row = '0;
        for (int w = 0; w < WAYS; w++)
        begin
            rst_row.rank[w] = RANK_W'(w);
        end
    end

    // Set memory write port: clearing pass or stage-1 update
    assign ram_wr_en   = clr_active_reg || row_we;
    assign ram_wr_addr = clr_active_reg ? clr_idx_reg : s1_set_reg;
    assign ram_wr_data = clr_active_reg ? ROW_W'(rst_row) : lk_row;

    sawbc_tag_ram #(
        .WIDTH (ROW_W),
        .DEPTH (SETS)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (in_set),
        .rd_data (ram_rd_data)
    );

    // Stage 1 control: valid and bypass flag
    always_comb
    begin
        byp_next = byp_reg;
        if (accept)
        begin
            byp_next = row_we && (s1_set_reg == in_set);
        end
        else if (s1_adv)
        begin
            byp_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            byp_reg      <= 1'b0;
        end
        else
        begin
            byp_reg <= byp_next;
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // Stage 1 payload: request fields and forwarded row
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= req.cmd;
            s1_tag_reg  <= in_tag;
            s1_set_reg  <= in_set;
            s1_sel_reg  <= req.counter_select;
            byp_row_reg <= lk_row;
        end
    end

    assign s1_row = byp_reg ? byp_row_reg : ram_rd_data;

    sawbc_lookup #(
        .WAYS  (WAYS),
        .TAG_W (TAG_W)
    ) u_lookup (
        .cmd      (s1_cmd_reg),
        .tag      (s1_tag_reg),
        .mode     (mode_reg),
        .row      (s1_row),
        .row_new  (lk_row),
        .row_we   (lk_we),
        .hit      (lk_hit),
        .wb_valid (lk_wb_valid),
        .wb_tag   (lk_wb_tag),
        .evt      (evt)
    );

    // Event counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_cnt_reg   <= '0;
            miss_cnt_reg  <= '0;
            evict_cnt_reg <= '0;
            wb_cnt_reg    <= '0;
        end
        else if (s1_fire)
        begin
            if (s1_cmd_reg == CMD_CLEAR_CNT)
            begin
                hit_cnt_reg   <= '0;
                miss_cnt_reg  <= '0;
                evict_cnt_reg <= '0;
                wb_cnt_reg    <= '0;
            end
            else
            begin
                hit_cnt_reg   <= hit_cnt_reg + CNT_W'(evt.hit);
                miss_cnt_reg  <= miss_cnt_reg + CNT_W'(evt.miss);
                evict_cnt_reg <= evict_cnt_reg + CNT_W'(evt.evict);
                wb_cnt_reg    <= wb_cnt_reg + CNT_W'(evt.wback);
            end
        end
    end

    always_comb
    begin
        unique case (s1_sel_reg)
            SEL_HITS:       cnt_sel = hit_cnt_reg;
            SEL_MISSES:     cnt_sel = miss_cnt_reg;
            SEL_EVICTIONS:  cnt_sel = evict_cnt_reg;
            SEL_WRITEBACKS: cnt_sel = wb_cnt_reg;
            default:        cnt_sel = '0;
        endcase
    end

    // Assemble the response
    always_comb
    begin
        rsp_next.hit             = lk_hit;
        rsp_next.writeback_valid = lk_wb_valid;
        rsp_next.writeback_address = '0;
        if (lk_wb_valid)
        begin
            rsp_next.writeback_address = (ADDR_W'(lk_wb_tag) << (OFF_W + SET_W))
                                       | (ADDR_W'(s1_set_reg) << OFF_W);
        end
        rsp_next.counter_value = (s1_cmd_reg == CMD_READ_CNT) ? cnt_sel : '0;
    end

    // Response register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            rsp_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

`ifndef ASSERT_OFF
    a_no_update_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        row_we |-> !clr_active_reg)
        else $error("set row update during clearing pass");

    a_bypass_has_item: assert property (@(posedge clk) disable iff (!rst_n)
        byp_reg |-> s1_valid_reg)
        else $error("forwarded row without a request in stage 1");

    a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && evt.evict |-> evt.miss && !evt.hit)
        else $error("eviction counted on a hit");

    a_counter_rsp_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && (rsp_reg.counter_value != '0)
            |-> !rsp_reg.hit && !rsp_reg.writeback_valid)
        else $error("counter response carries lookup results");
`endif

endmodule

>>> hw/rtl/sawbc_tag_ram.sv
// Single-port-write, single-port-read set memory with registered read data.
// Holds one row of per-way state per set; no package dependency.
module sawbc_tag_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, hold data when not enabled
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> hw/rtl/sawbc_lookup.sv
// Per-set tag compare, victim choice, recency update and writeback decision.
// Pure combinational update of one set row; uses sawbc_pkg.
module sawbc_lookup #(
    parameter int WAYS = 4,
    parameter int TAG_W = 51,
    localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1,
    localparam int ROW_W = WAYS * (2 + TAG_W + RANK_W)
) (
    input  logic [sawbc_pkg::CMD_W-1:0] cmd,
    input  logic [TAG_W-1:0]            tag,
    input  logic                        mode,
    input  logic [ROW_W-1:0]            row,
    output logic [ROW_W-1:0]            row_new,
    output logic                        row_we,
    output logic                        hit,
    output logic                        wb_valid,
    output logic [TAG_W-1:0]            wb_tag,
    output sawbc_pkg::cnt_evt_t         evt
);
    import sawbc_pkg::*;

    typedef struct packed {
        logic [WAYS-1:0]              valid;
        logic [WAYS-1:0]              dirty;
        logic [WAYS-1:0][TAG_W-1:0]   tag;
        logic [WAYS-1:0][RANK_W-1:0]  rank;
    } row_t;

    row_t              cur;
    row_t              nxt;
    logic [WAYS-1:0]   hit_vec;
    logic              found;
    logic              any_inv;
    logic [RANK_W-1:0] hit_way;
    logic [RANK_W-1:0] inv_way;
    logic [RANK_W-1:0] lru_way;
    logic [RANK_W-1:0] fill_way;
    logic [RANK_W-1:0] tgt_way;
    logic [RANK_W-1:0] tgt_rank;
    logic              access;
    logic              looks;
    logic              evict;

    // Compare all ways and pick lowest hit, invalid and rank-zero ways
    always_comb
    begin
        cur     = row_t'(row);
        hit_vec = '0;
        hit_way = '0;
        inv_way = '0;
        lru_way = '0;
        for (int w = WAYS - 1; w >= 0; w--)
        begin
            hit_vec[w] = cur.valid[w] && (cur.tag[w] == tag);
            if (hit_vec[w])
            begin
                hit_way = RANK_W'(w);
            end
            if (!cur.valid[w])
            begin
                inv_way = RANK_W'(w);
            end
            if (cur.rank[w] == '0)
            begin
                lru_way = RANK_W'(w);
            end
        end
        found   = |hit_vec;
        any_inv = ~&cur.valid;
    end

    // Decode command class
    always_comb
    begin
        access = 1'b0;
        looks  = 1'b0;
        unique case (cmd)
            CMD_READ, CMD_WRITE:
            begin
                access = 1'b1;
                looks  = 1'b1;
            end
            CMD_PROBE, CMD_INVALIDATE, CMD_FLUSH:
            begin
                looks = 1'b1;
            end
            default:
            begin
                looks = 1'b0;
            end
        endcase
    end

    assign fill_way = any_inv ? inv_way : (mode ? '0 : lru_way);
    assign tgt_way  = found ? hit_way : fill_way;
    assign evict    = access && !found && !any_inv;

    // Build the updated row and writeback report
    always_comb
    begin
        nxt      = cur;
        wb_valid = 1'b0;
        wb_tag   = tag;
        tgt_rank = cur.rank[tgt_way];
        if (access)
        begin
            if (found)
            begin
                if (cmd == CMD_WRITE)
                begin
                    nxt.dirty[hit_way] = 1'b1;
                end
            end
            else
            begin
                if (evict && cur.dirty[fill_way])
                begin
                    wb_valid = 1'b1;
                    wb_tag   = cur.tag[fill_way];
                end
                nxt.valid[fill_way] = 1'b1;
                nxt.tag[fill_way]   = tag;
                nxt.dirty[fill_way] = (cmd == CMD_WRITE);
            end
            // Move the touched way to most recent
            for (int w = 0; w < WAYS; w++)
            begin
                if (cur.rank[w] > tgt_rank)
                begin
                    nxt.rank[w] = cur.rank[w] - 1'b1;
                end
            end
            nxt.rank[tgt_way] = RANK_W'(WAYS - 1);
        end
        else if (cmd == CMD_INVALIDATE && found)
        begin
            wb_valid           = cur.dirty[hit_way];
            nxt.valid[hit_way] = 1'b0;
            nxt.dirty[hit_way] = 1'b0;
        end
        else if (cmd == CMD_FLUSH && found && cur.dirty[hit_way])
        begin
            wb_valid           = 1'b1;
            nxt.dirty[hit_way] = 1'b0;
        end
    end

    assign row_new   = ROW_W'(nxt);
    assign row_we    = looks;
    assign hit       = looks && found;
    assign evt.hit   = access && found;
    assign evt.miss  = access && !found;
    assign evt.evict = evict;
    assign evt.wback = wb_valid;

endmodule

>>> tb/set_assoc_writeback_cache_tags_core_tb.sv
`timescale 1ns / 100ps
// Testbench for set_assoc_writeback_cache_tags_core: sends cache commands over the
// request channel and checks each response against a behavioral model of the tags,
// dirty bits, LRU ranks and counters. Depends on sawbc_pkg.
module set_assoc_writeback_cache_tags_core_tb;
    import sawbc_pkg::*;

    localparam int LINE_BYTES   = 64;
    localparam int SETS         = 128;
    localparam int WAYS         = 4;
    localparam int SLOTS        = SETS * WAYS;
    localparam int OFFSET_W     = $clog2(LINE_BYTES);
    localparam int SET_W        = $clog2(SETS);
    localparam int TAG_W        = ADDR_W - OFFSET_W - SET_W;
    localparam int RANK_W       = $clog2(WAYS);
    localparam int IDLE_LIMIT   = 5000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    // Command with no effect
    localparam logic [CMD_W-1:0] CMD_NONE = 3'd7;

    // Replacement mode values
    localparam logic MODE_LRU  = 1'b0;
    localparam logic MODE_WAY0 = 1'b1;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;
    logic cfg_write = 1'b0;
    logic cfg_data  = 1'b0;

    // Cache state as the block should hold it
    logic              line_present  [SLOTS];
    logic              line_modified [SLOTS];
    logic [TAG_W-1:0]  line_tag_q    [SLOTS];
    logic [RANK_W-1:0] way_rank      [SLOTS];
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  miss_total;
    logic [CNT_W-1:0]  evict_total;
    logic [CNT_W-1:0]  wback_total;
    logic              victim_mode;

    rsp_t expected_rsp [$];

    bit pace_gaps     = 1'b1;
    bit mismatch_seen = 1'b0;
    int hold_left     = 0;
    int stall_left    = 0;
    int idle_cycles   = 0;

    logic [TAG_W-1:0] tag_pool [8];
    logic [SET_W-1:0] set_pool [4];

    set_assoc_writeback_cache_tags_core #(
        .LINE_BYTES(LINE_BYTES),
        .SETS(SETS),
        .WAYS(WAYS)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req(req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp),
        .cfg_write(cfg_write),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    function automatic logic [ADDR_W-1:0] line_addr(logic [TAG_W-1:0] tag,
                                                    logic [SET_W-1:0] set_idx);
        return {tag, set_idx, {OFFSET_W{1'b0}}};
    endfunction

    // Apply one command to the cache state and return the response it should give
    function automatic rsp_t predict_access(req_t r);
        rsp_t              o;
        logic [SET_W-1:0]  set_idx;
        logic [TAG_W-1:0]  tag;
        logic [RANK_W-1:0] old_rank;
        int                base;
        int                way;
        o       = '0;
        set_idx = r.address[OFFSET_W +: SET_W];
        tag     = r.address[ADDR_W-1 -: TAG_W];
        base    = int'(set_idx) * WAYS;
        way     = -1;
        // look up the lowest valid way with a matching tag
        if (r.cmd <= CMD_FLUSH)
        begin
            for (int w = WAYS - 1; w >= 0; w--)
                if (line_present[base + w] && line_tag_q[base + w] == tag)
                    way = w;
            o.hit = (way >= 0);
        end
        case (r.cmd)
            CMD_READ, CMD_WRITE:
            begin
                if (way >= 0)
                begin
                    hit_total++;
                    if (r.cmd == CMD_WRITE)
                        line_modified[base + way] = 1'b1;
                end
                else
                begin
                    miss_total++;
                    // fill the lowest invalid way, else evict a victim
                    for (int w = WAYS - 1; w >= 0; w--)
                        if (!line_present[base + w])
                            way = w;
                    if (way < 0)
                    begin
                        way = 0;
                        if (victim_mode == MODE_LRU)
                            for (int w = 0; w < WAYS; w++)
                                if (way_rank[base + w] == '0)
                                    way = w;
                        evict_total++;
                        if (line_modified[base + way])
                        begin
                            o.writeback_valid   = 1'b1;
                            o.writeback_address = line_addr(line_tag_q[base + way], set_idx);
                            wback_total++;
                        end
                    end
                    line_present[base + way]  = 1'b1;
                    line_tag_q[base + way]    = tag;
                    line_modified[base + way] = (r.cmd == CMD_WRITE);
                end
                // make the touched way most recent
                old_rank = way_rank[base + way];
                for (int w = 0; w < WAYS; w++)
                    if (way_rank[base + w] > old_rank)
                        way_rank[base + w]--;
                way_rank[base + way] = RANK_W'(WAYS - 1);
            end
            CMD_INVALIDATE:
            begin
                if (way >= 0)
                begin
                    if (line_modified[base + way])
                    begin
                        o.writeback_valid   = 1'b1;
                        o.writeback_address = line_addr(tag, set_idx);
                        wback_total++;
                    end
                    line_present[base + way]  = 1'b0;
                    line_modified[base + way] = 1'b0;
                end
            end
            CMD_FLUSH:
            begin
                if (way >= 0 && line_modified[base + way])
                begin
                    o.writeback_valid   = 1'b1;
                    o.writeback_address = line_addr(tag, set_idx);
                    wback_total++;
                    line_modified[base + way] = 1'b0;
                end
            end
            CMD_READ_CNT:
            begin
                case (r.counter_select)
                    SEL_HITS:      o.counter_value = hit_total;
                    SEL_MISSES:    o.counter_value = miss_total;
                    SEL_EVICTIONS: o.counter_value = evict_total;
                    default:       o.counter_value = wback_total;
                endcase
            end
            CMD_CLEAR_CNT:
            begin
                hit_total   = '0;
                miss_total  = '0;
                evict_total = '0;
                wback_total = '0;
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    // Mostly no gap, some short ones, a few long ones
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 55)
            return 0;
        if (p < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic req_t make_req(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] address,
                                      logic [SEL_W-1:0] counter_select);
        req_t r;
        r.cmd            = cmd;
        r.address        = address;
        r.counter_select = counter_select;
        return r;
    endfunction

    // Mostly addresses from a few hot sets and tags, so lines hit, fill and evict
    function automatic req_t random_request(int set_spread);
        req_t r;
        int   p;
        r.counter_select = SEL_W'($urandom);
        p = $urandom_range(0, 99);
        if (p < 30)
            r.cmd = CMD_READ;
        else if (p < 60)
            r.cmd = CMD_WRITE;
        else if (p < 70)
            r.cmd = CMD_PROBE;
        else if (p < 78)
            r.cmd = CMD_INVALIDATE;
        else if (p < 88)
            r.cmd = CMD_FLUSH;
        else if (p < 95)
            r.cmd = CMD_READ_CNT;
        else if (p < 98)
            r.cmd = CMD_CLEAR_CNT;
        else
            r.cmd = CMD_NONE;
        if ($urandom_range(0, 9) == 0)
            r.address = {$urandom, $urandom};
        else
            r.address = line_addr(tag_pool[$urandom_range(0, 7)],
                                  set_pool[$urandom_range(0, set_spread - 1)])
                        | ADDR_W'($urandom_range(0, LINE_BYTES - 1));
        return r;
    endfunction

    // Offer one request, hold it until accepted, then record its expected response
    task automatic send_request(input req_t item);
        int gap;
        gap = pace_gaps ? pick_gap() : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        expected_rsp.push_back(predict_access(item));
    endtask

    // Drop valid and wait until every expected response has come back
    task automatic wait_drained();
        @(negedge clk);
        req_valid <= 1'b0;
        while (expected_rsp.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_replacement(input logic mode);
        wait_drained();
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= mode;
        @(negedge clk);
        cfg_write <= 1'b0;
        victim_mode = mode;
    endtask

    // Fill one set, evict, probe, flush, invalidate, counters and the idle command
    task automatic test_directed();
        send_request(make_req(CMD_WRITE, line_addr(51'd0, 7'd0), SEL_HITS));
        send_request(make_req(CMD_READ, line_addr(51'd1, 7'd0), SEL_HITS));
        send_request(make_req(CMD_WRITE, line_addr(51'd2, 7'd0) | 64'd63, SEL_HITS));
        send_request(make_req(CMD_READ, line_addr(51'd3, 7'd0), SEL_HITS));
        send_request(make_req(CMD_READ, line_addr(51'd4, 7'd0), SEL_HITS));
        send_request(make_req(CMD_PROBE, line_addr(51'd1, 7'd0), SEL_HITS));
        send_request(make_req(CMD_PROBE, line_addr(51'd0, 7'd0), SEL_HITS));
        send_request(make_req(CMD_FLUSH, line_addr(51'd2, 7'd0), SEL_HITS));
        send_request(make_req(CMD_FLUSH, line_addr(51'd2, 7'd0), SEL_HITS));
        send_request(make_req(CMD_FLUSH, line_addr(51'd0, 7'd0), SEL_HITS));
        send_request(make_req(CMD_WRITE, line_addr(51'd1, 7'd0), SEL_HITS));
        send_request(make_req(CMD_INVALIDATE, line_addr(51'd1, 7'd0), SEL_HITS));
        send_request(make_req(CMD_INVALIDATE, line_addr(51'd3, 7'd0), SEL_HITS));
        send_request(make_req(CMD_INVALIDATE, line_addr(51'd1, 7'd0), SEL_HITS));
        send_request(make_req(CMD_READ, {ADDR_W{1'b1}}, SEL_HITS));
        send_request(make_req(CMD_WRITE, '0, SEL_HITS));
        send_request(make_req(CMD_WRITE, {ADDR_W{1'b1}}, SEL_HITS));
        send_request(make_req(CMD_FLUSH, {ADDR_W{1'b1}}, SEL_HITS));
        send_request(make_req(CMD_READ_CNT, '0, SEL_HITS));
        send_request(make_req(CMD_READ_CNT, '0, SEL_MISSES));
        send_request(make_req(CMD_READ_CNT, '0, SEL_EVICTIONS));
        send_request(make_req(CMD_READ_CNT, '0, SEL_WRITEBACKS));
        send_request(make_req(CMD_CLEAR_CNT, '0, SEL_HITS));
        send_request(make_req(CMD_NONE, {ADDR_W{1'b1}}, SEL_WRITEBACKS));
        send_request(make_req(CMD_READ_CNT, '0, SEL_MISSES));
    endtask

    task automatic test_lru_random();
        repeat (500) send_request(random_request(4));
    endtask

    // Victim is always way zero; crowd one or two sets so it evicts often
    task automatic test_way_zero();
        set_replacement(MODE_WAY0);
        repeat (300) send_request(random_request($urandom_range(1, 2)));
        set_replacement(MODE_LRU);
    endtask

    // Hold the response side off while requests keep coming, so the block backs up
    task automatic test_backpressure();
        pace_gaps = 1'b0;
        @(posedge clk);
        hold_left = HOLD_CYCLES;
        repeat (60) send_request(random_request(2));
        pace_gaps = 1'b1;
    endtask

    // Pause the sender until every response is back, then resume
    task automatic test_drain_pause();
        repeat (30) send_request(random_request(4));
        wait_drained();
        repeat (30) send_request(random_request(4));
    endtask

    // Stretches with and without gaps, last stretch in way-zero mode
    task automatic test_mixed_random();
        for (int phase = 0; phase < 4; phase++)
        begin
            pace_gaps = (phase != 2);
            if (phase == 3)
                set_replacement(MODE_WAY0);
            repeat (170) send_request(random_request(4));
        end
        pace_gaps = 1'b1;
    endtask

    // Response side: hold-off first, then random stalls
    always @(negedge clk)
    begin
        int n;
        if (hold_left > 0)
        begin
            rsp_stall <= 1'b1;
            hold_left--;
        end
        else if (stall_left > 0)
        begin
            rsp_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            n = pace_gaps ? pick_gap() : 0;
            rsp_stall  <= (n > 0);
            stall_left = (n > 0) ? n - 1 : 0;
        end
    end

    // Compare each accepted response with the oldest expectation
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (expected_rsp.size() == 0)
            begin
                $error("response with none expected: %p", rsp);
                mismatch_seen = 1'b1;
            end
            else
            begin
                want = expected_rsp.pop_front();
                if (rsp.hit !== want.hit)
                begin
                    $error("hit: expected %0d, got %0d", want.hit, rsp.hit);
                    mismatch_seen = 1'b1;
                end
                if (rsp.writeback_valid !== want.writeback_valid)
                begin
                    $error("writeback_valid: expected %0d, got %0d",
                           want.writeback_valid, rsp.writeback_valid);
                    mismatch_seen = 1'b1;
                end
                if (rsp.writeback_address !== want.writeback_address)
                begin
                    $error("writeback_address: expected %h, got %h",
                           want.writeback_address, rsp.writeback_address);
                    mismatch_seen = 1'b1;
                end
                if (rsp.counter_value !== want.counter_value)
                begin
                    $error("counter_value: expected %0d, got %0d",
                           want.counter_value, rsp.counter_value);
                    mismatch_seen = 1'b1;
                end
            end
        end
    end

    // End the run when nothing moves on either channel for too long
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        // cache state after reset: all invalid, rank equals way index
        for (int i = 0; i < SLOTS; i++)
        begin
            line_present[i]  = 1'b0;
            line_modified[i] = 1'b0;
            line_tag_q[i]    = '0;
            way_rank[i]      = RANK_W'(i % WAYS);
        end
        hit_total   = '0;
        miss_total  = '0;
        evict_total = '0;
        wback_total = '0;
        victim_mode = MODE_LRU;

        // hot tags and sets, extremes included
        tag_pool[0] = '0;
        tag_pool[1] = '1;
        tag_pool[2] = TAG_W'(1);
        for (int i = 3; i < 8; i++)
            tag_pool[i] = TAG_W'({$urandom, $urandom});
        set_pool[0] = '0;
        set_pool[1] = '1;
        set_pool[2] = SET_W'($urandom);
        set_pool[3] = SET_W'($urandom);

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_lru_random();
        test_way_zero();
        test_backpressure();
        test_drain_pause();
        test_mixed_random();

        wait_drained();
        if (!mismatch_seen && expected_rsp.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

>>> set_assoc_writeback_cache_tags_core.f
hw/rtl/sawbc_pkg.sv
hw/rtl/sawbc_tag_ram.sv
hw/rtl/sawbc_lookup.sv
hw/rtl/set_assoc_writeback_cache_tags_core.sv
tb/set_assoc_writeback_cache_tags_core_tb.sv
